[rtl/price_level_book_add_sweep_defines.svh]
// Assertion macros for the price level book.
`ifndef PRICE_LEVEL_BOOK_ADD_SWEEP_DEFINES_SVH
`define PRICE_LEVEL_BOOK_ADD_SWEEP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define PLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/plb_pkg.sv]
// Package with payload types, function codes and state codes.
`timescale 1ns / 1ps
`default_nettype none
package plb_pkg;
  typedef struct packed {
    logic        func;
    logic        order_side;
    logic [31:0] order_price;
    logic [31:0] order_qty;
  } plb_in_t;

  typedef struct packed {
    logic [31:0] executed_qty;
    logic        add_dropped;
  } plb_out_t;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_EXEC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_SWEEP,
    ST_DONE
  } plb_state_t;
endpackage
`default_nettype wire

[rtl/plb_level_unit.sv]
// Shared compare and add/subtract unit used once per sequencer step.
`timescale 1ns / 1ps
`default_nettype none
module plb_level_unit (
  input  wire logic        is_bid,
  input  wire logic [31:0] lvl_price,
  input  wire logic [31:0] lvl_qty,
  input  wire logic [31:0] ord_price,
  input  wire logic [31:0] ord_qty,
  output logic             ahead,
  output logic             same,
  output logic [31:0]      sat_sum,
  output logic             lvl_le,
  output logic [31:0]      diff
);
  logic [32:0] sum;
  logic [32:0] sub;
  always_comb begin
    ahead   = is_bid ? (lvl_price > ord_price) : (lvl_price < ord_price);
    same    = (lvl_price == ord_price);
    sum     = {1'b0, lvl_qty} + {1'b0, ord_qty};
    sat_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    // ord_qty minus level qty; borrow means level exceeds the remainder
    sub     = {1'b0, ord_qty} - {1'b0, lvl_qty};
    lvl_le  = !sub[32];
    diff    = sub[32] ? (lvl_qty - ord_qty) : sub[31:0];
  end
endmodule
`default_nettype wire

[rtl/price_level_book_add_sweep.sv]
// Top level: two sorted level tables walked by one shared level unit.
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid/in_ready    | plb_in_t
// out     | out | out_valid/out_ready  | plb_out_t
// Add: scans levels up to the match or insert point, then moves the levels
//   below it down one per step.
// Execute: sweeps levels one per step, then moves the rest up one per step.
// The shared compare/add unit sets one step per cycle; no input while busy.
// Reset (rst_n low, synchronous) empties both sides; level contents are not cleared.
// A waiting result holds the block until taken.
`timescale 1ns / 1ps
`default_nettype none
module price_level_book_add_sweep #(
  parameter int LEVELS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire plb_pkg::plb_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output plb_pkg::plb_out_t     out_data
);
  import plb_pkg::*;
  `include "price_level_book_add_sweep_defines.svh"

  localparam int IW = $clog2(LEVELS);
  localparam int CW = $clog2(LEVELS + 1);
  localparam logic [CW-1:0] FULL = CW'(LEVELS);

  // index 0 bids, 1 asks
  logic [31:0] px_r [2][LEVELS];
  logic [31:0] qt_r [2][LEVELS];
  logic [CW-1:0] cnt_r [2];

  plb_state_t state_r, state_nxt;
  plb_in_t    req_r;
  logic       sd_r;            // side table in use
  logic [CW-1:0] pos_r, pos_nxt;  // scan position / levels gone
  logic [CW-1:0] j_r, j_nxt;      // shift index
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic        drop_r, drop_nxt;

  logic [IW-1:0] pidx;
  logic [31:0] lp, lq;
  logic ahead, same, lvl_le;
  logic [31:0] sat_sum, diff;
  logic [CW-1:0] n;

  assign n    = cnt_r[sd_r];
  assign pidx = pos_r[IW-1:0];
  assign lp   = px_r[sd_r][pidx];
  assign lq   = qt_r[sd_r][pidx];

  plb_level_unit u_unit (
    .is_bid   (!sd_r),
    .lvl_price(lp),
    .lvl_qty  (lq),
    .ord_price(req_r.order_price),
    .ord_qty  (rem_r),
    .ahead    (ahead),
    .same     (same),
    .sat_sum  (sat_sum),
    .lvl_le   (lvl_le),
    .diff     (diff)
  );

  logic [IW-1:0] jidx, jm1, jsrc;
  logic [CW-1:0] jsum;
  assign jidx = j_r[IW-1:0];
  assign jm1  = jidx - 1'b1;
  assign jsum = j_r + pos_r;
  assign jsrc = jsum[IW-1:0];

  // sweep shift ends when source runs past count; add shift when j reaches pos
  logic shift_end;
  assign shift_end = (req_r.func == FUNC_ADD) ? (j_r <= pos_r) : !(jsum < n);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        if (in_data.order_qty == '0) state_nxt = ST_DONE;
        else if (in_data.func == FUNC_ADD) state_nxt = ST_SCAN;
        else state_nxt = ST_SWEEP;
      end
      ST_SCAN: begin
        if (pos_r < n && ahead) state_nxt = ST_SCAN;
        else if (pos_r < n && same) state_nxt = ST_DONE;
        else if (n == FULL) state_nxt = ST_DONE;
        else state_nxt = ST_SHIFT;
      end
      ST_SHIFT: if (shift_end) state_nxt = ST_DONE;
      ST_SWEEP: begin
        if (pos_r < n && rem_r != '0 && lvl_le) state_nxt = ST_SWEEP;
        else if (pos_r == '0) state_nxt = ST_DONE;
        else state_nxt = ST_SHIFT;
      end
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    pos_nxt  = pos_r;
    j_nxt    = j_r;
    rem_nxt  = rem_r;
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    unique case (state_r)
      ST_IDLE: begin
        pos_nxt  = '0;
        j_nxt    = '0;
        rem_nxt  = in_data.order_qty;
        fill_nxt = '0;
        drop_nxt = 1'b0;
      end
      ST_SCAN: begin
        if (pos_r < n && ahead) pos_nxt = pos_r + 1'b1;
        else if (!(pos_r < n && same) && n == FULL) drop_nxt = 1'b1;
        j_nxt = n;
      end
      ST_SHIFT: j_nxt = (req_r.func == FUNC_ADD) ? j_r - 1'b1 : j_r + 1'b1;
      ST_SWEEP: begin
        if (pos_r < n && rem_r != '0) begin
          if (lvl_le) begin
            rem_nxt  = diff;
            fill_nxt = fill_r + lq;
            pos_nxt  = pos_r + 1'b1;
          end else begin
            fill_nxt = fill_r + rem_r;
            rem_nxt  = '0;
          end
        end
        j_nxt = '0;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    state_r <= rst_n ? state_nxt : ST_IDLE;
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else begin
      unique case (state_r)
        ST_SCAN: if (pos_r < n && !ahead && same) qt_r[sd_r][pidx] <= sat_sum;
        ST_SHIFT: begin
          if (req_r.func == FUNC_ADD) begin
            if (j_r > pos_r) begin
              px_r[sd_r][jidx] <= px_r[sd_r][jm1];
              qt_r[sd_r][jidx] <= qt_r[sd_r][jm1];
            end else begin
              px_r[sd_r][pidx] <= req_r.order_price;
              qt_r[sd_r][pidx] <= req_r.order_qty;
              cnt_r[sd_r] <= n + 1'b1;
            end
          end else begin
            if (jsum < n) begin
              px_r[sd_r][jidx] <= px_r[sd_r][jsrc];
              qt_r[sd_r][jidx] <= qt_r[sd_r][jsrc];
            end else begin
              cnt_r[sd_r] <= n - pos_r;
            end
          end
        end
        ST_SWEEP: if (pos_r < n && rem_r != '0 && !lvl_le) qt_r[sd_r][pidx] <= diff;
        default: ;
      endcase
    end
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= in_data;
      sd_r  <= (in_data.func == FUNC_ADD) ? in_data.order_side : !in_data.order_side;
    end
    pos_r  <= pos_nxt;
    j_r    <= j_nxt;
    rem_r  <= rem_nxt;
    fill_r <= fill_nxt;
    drop_r <= drop_nxt;
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
    out_data.executed_qty = fill_r;
    out_data.add_dropped  = drop_r;
  end

  `PLB_ASSERT_IMP(a_cnt_bid, 1'b1, cnt_r[0] <= FULL, "bid count over depth")
  `PLB_ASSERT_IMP(a_cnt_ask, 1'b1, cnt_r[1] <= FULL, "ask count over depth")
  `PLB_ASSERT_IMP(a_drop_add, out_valid && out_data.add_dropped, req_r.func == FUNC_ADD, "drop")
  `PLB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed")
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the price level book: add and market sweep against a local book model.
`timescale 1ns / 1ps
module tb_top;
  import plb_pkg::*;

  localparam int LEVELS = 16;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  plb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  plb_out_t out_data;

  always #6 clk = ~clk;

  price_level_book_add_sweep #(.LEVELS(LEVELS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // book model
  logic [31:0] bid_px[LEVELS], bid_qt[LEVELS], ask_px[LEVELS], ask_qt[LEVELS];
  int          bid_cnt = 0, ask_cnt = 0;
  plb_out_t    pending_fills[$];
  int          errors = 0, n_sent = 0, n_checked = 0, n_drops = 0, n_fills = 0;

  function automatic plb_out_t book_apply(plb_in_t t);
    plb_out_t    r;
    logic        is_bid;
    int          n, pos, gone;
    logic [31:0] rem;
    logic [32:0] sum;
    r = '0;
    if (t.func == FUNC_ADD) begin
      is_bid = (t.order_side == SIDE_BUY);
      n = is_bid ? bid_cnt : ask_cnt;
      if (t.order_qty == 0) return r;
      pos = 0;
      while (pos < n && (is_bid ? bid_px[pos] > t.order_price
                                : ask_px[pos] < t.order_price)) pos++;
      if (pos < n && (is_bid ? bid_px[pos] : ask_px[pos]) == t.order_price) begin
        sum = (is_bid ? bid_qt[pos] : ask_qt[pos]) + t.order_qty;
        if (sum[32]) sum = 33'hFFFFFFFF;
        if (is_bid) bid_qt[pos] = sum[31:0];
        else ask_qt[pos] = sum[31:0];
        return r;
      end
      if (n >= LEVELS) begin
        r.add_dropped = 1'b1;
        return r;
      end
      for (int j = n; j > pos; j--) begin
        if (is_bid) begin
          bid_px[j] = bid_px[j-1]; bid_qt[j] = bid_qt[j-1];
        end else begin
          ask_px[j] = ask_px[j-1]; ask_qt[j] = ask_qt[j-1];
        end
      end
      if (is_bid) begin
        bid_px[pos] = t.order_price; bid_qt[pos] = t.order_qty; bid_cnt++;
      end else begin
        ask_px[pos] = t.order_price; ask_qt[pos] = t.order_qty; ask_cnt++;
      end
    end else begin
      // buy sweeps asks, sell sweeps bids
      is_bid = (t.order_side == SIDE_SELL);
      n = is_bid ? bid_cnt : ask_cnt;
      rem = t.order_qty;
      gone = 0;
      while (gone < n && rem > 0) begin
        if (is_bid) begin
          if (bid_qt[gone] <= rem) begin
            rem -= bid_qt[gone]; r.executed_qty += bid_qt[gone]; gone++;
          end else begin
            bid_qt[gone] -= rem; r.executed_qty += rem; rem = 0;
          end
        end else begin
          if (ask_qt[gone] <= rem) begin
            rem -= ask_qt[gone]; r.executed_qty += ask_qt[gone]; gone++;
          end else begin
            ask_qt[gone] -= rem; r.executed_qty += rem; rem = 0;
          end
        end
      end
      for (int j = 0; j + gone < n; j++) begin
        if (is_bid) begin
          bid_px[j] = bid_px[j+gone]; bid_qt[j] = bid_qt[j+gone];
        end else begin
          ask_px[j] = ask_px[j+gone]; ask_qt[j] = ask_qt[j+gone];
        end
      end
      if (is_bid) bid_cnt = n - gone;
      else ask_cnt = n - gone;
    end
    return r;
  endfunction

  // called and returns at a falling edge; valid stays high when no gap follows
  task automatic send_order(logic f, logic s, logic [31:0] p, logic [31:0] q);
    plb_in_t t;
    int      gap;
    t.func = f; t.order_side = s; t.order_price = p; t.order_qty = q;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_fills.push_back(book_apply(t));
    n_sent++;
    if (t.func == FUNC_EXEC && pending_fills[$].executed_qty != 0) n_fills++;
    if (pending_fills[$].add_dropped) n_drops++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_fills.size() == 0) begin
        $display("%0t: unexpected result exp=none act=%h", $time, out_data);
        errors++;
      end else begin
        if (out_data.executed_qty !== pending_fills[0].executed_qty) begin
          $display("%0t: executed_qty exp=%0d act=%0d", $time,
                   pending_fills[0].executed_qty, out_data.executed_qty);
          errors++;
        end
        if (out_data.add_dropped !== pending_fills[0].add_dropped) begin
          $display("%0t: add_dropped exp=%0b act=%0b", $time,
                   pending_fills[0].add_dropped, out_data.add_dropped);
          errors++;
        end
        void'(pending_fills.pop_front());
        n_checked++;
      end
    end
  end

  // receiver stalls
  initial begin
    int w;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (w > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (w - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic test_directed();
    send_order(FUNC_EXEC, SIDE_BUY, 32'd0, 32'd5);           // empty asks
    send_order(FUNC_EXEC, SIDE_SELL, 32'd0, 32'd5);          // empty bids
    send_order(FUNC_ADD, SIDE_BUY, 32'd100, 32'd0);          // zero qty add
    send_order(FUNC_ADD, SIDE_BUY, 32'd0, 32'hFFFFFFFF);
    send_order(FUNC_ADD, SIDE_BUY, 32'hFFFFFFFF, 32'd1);
    send_order(FUNC_ADD, SIDE_BUY, 32'hFFFFFFFF, 32'hFFFFFFFF); // saturate
    send_order(FUNC_ADD, SIDE_SELL, 32'hFFFFFFFF, 32'd7);
    send_order(FUNC_ADD, SIDE_SELL, 32'd0, 32'd3);
    send_order(FUNC_ADD, SIDE_SELL, 32'd50, 32'd4);
    send_order(FUNC_EXEC, SIDE_BUY, 32'hFFFFFFFF, 32'd0);    // zero qty sweep
    send_order(FUNC_EXEC, SIDE_BUY, 32'd0, 32'd5);           // partial level
    send_order(FUNC_EXEC, SIDE_BUY, 32'd0, 32'hFFFFFFFF);    // clears asks
    for (int i = 0; i < 17; i++)                             // fill, then drop
      send_order(FUNC_ADD, SIDE_SELL, 32'd1000 + i, 32'd1 + i);
    send_order(FUNC_EXEC, SIDE_SELL, 32'd0, 32'hFFFFFFFF);   // sweeps the top bid
  endtask

  task automatic test_random(int count);
    logic [31:0] p, q;
    for (int i = 0; i < count; i++) begin
      // narrow prices so levels collide; occasionally full range
      p = ($urandom_range(0, 9) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 24);
      case ($urandom_range(0, 3))
        0: q = $urandom;
        1: q = 32'hFFFFFFFF - $urandom_range(0, 3);
        default: q = $urandom_range(0, 200);
      endcase
      send_order(($urandom_range(0, 9) < 6) ? FUNC_ADD : FUNC_EXEC,
                 1'($urandom_range(0, 1)), p, q);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(700);
    in_valid <= 1'b0;
    while (pending_fills.size() != 0) @(posedge clk);
    repeat (2 * LEVELS + 10) @(posedge clk);
    $display("Run: %0d transactions sent, %0d results checked, %0d fills, %0d dropped adds.",
             n_sent, n_checked, n_fills, n_drops);
    if (errors == 0) $display("[price_level_book_add_sweep] OK");
    else $display("[price_level_book_add_sweep] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[price_level_book_add_sweep] ERROR");
    $finish;
  end
endmodule
